// ----- design/axis_homing_sequencer_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the axis homing sequencer
// Immediate-consequence and next-cycle forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef AXIS_HOMING_SEQUENCER_TOP_ASSERT_SVH
`define AXIS_HOMING_SEQUENCER_TOP_ASSERT_SVH

// consequence must hold in the same cycle as the antecedent
`define AHS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ahs: assertion failed");

// consequence must hold in the cycle after the antecedent
`define AHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ahs: assertion failed");

`endif

// ----- design/ahs_pkg.sv -----
// ----------------------------------------------------------------------------
// ahs_pkg
// Types, phase codes and register indexes shared by the homing sequencer.
// ----------------------------------------------------------------------------
package ahs_pkg;

   localparam int AXIS_MAX          = 2;
   localparam int AXES_DEFAULT      = 2;
   localparam int POS_WIDTH_DEFAULT = 32;
   localparam int FIELD_WIDTH       = 32;
   localparam int TIMEOUT_WIDTH     = 10;
   localparam int HOME_STEP_WIDTH   = 16;
   localparam int PHASE_WIDTH       = 4;
   localparam int CSR_INDEX_WIDTH   = 3;
   localparam int CSR_DATA_WIDTH    = 32;

   localparam logic [TIMEOUT_WIDTH-1:0] POWER_TIMEOUT_RESET = 10'd1000;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SKIP_HOMING   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POWER_TIMEOUT = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_POS_A     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_POS_A     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_POS_B     = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_POS_B     = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOME_STEP_A   = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOME_STEP_B   = 3'd7;

   typedef enum logic [PHASE_WIDTH-1:0] {
      PH_OFF    = 4'd0,
      PH_START  = 4'd1,
      PH_WAIT   = 4'd2,
      PH_HOMING = 4'd3,
      PH_SEEK   = 4'd4,
      PH_BACK   = 4'd5,
      PH_HOMED  = 4'd6,
      PH_RUN    = 4'd7,
      PH_STOP   = 4'd8,
      PH_DONE   = 4'd9,
      PH_ERROR  = 4'd10
   } ahs_phase_type;

   typedef struct packed {
      logic                                         skip_homing;
      logic [TIMEOUT_WIDTH-1:0]                     power_timeout;
      logic [AXIS_MAX-1:0][FIELD_WIDTH-1:0]         max_pos;
      logic [AXIS_MAX-1:0][FIELD_WIDTH-1:0]         min_pos;
      logic [AXIS_MAX-1:0][HOME_STEP_WIDTH-1:0]     home_step;
   } ahs_cfg_type;

   typedef struct packed {
      logic                                 stop_request;
      logic                                 drives_ok;
      logic [AXIS_MAX-1:0]                  home;
      logic [AXIS_MAX-1:0][FIELD_WIDTH-1:0] target;
   } ahs_item_type;

   typedef struct packed {
      ahs_phase_type            phase;
      logic [TIMEOUT_WIDTH-1:0] wait_count;
      logic                     motion_enable;
      logic                     power_on;
   } ahs_ctrl_type;

   typedef struct packed {
      logic                                 power_on;
      logic [PHASE_WIDTH-1:0]               phase;
      logic                                 is_running;
      logic                                 is_fault;
      logic                                 finished;
      logic [AXIS_MAX-1:0][FIELD_WIDTH-1:0] pos;
      logic [AXIS_MAX-1:0][FIELD_WIDTH-1:0] steps;
   } ahs_result_type;

endpackage

// ----- design/ahs_req_if.sv -----
// ----------------------------------------------------------------------------
// ahs_req_if
// Control tick channel: valid/ready handshake plus the tick inputs.
// ----------------------------------------------------------------------------
interface ahs_req_if;
   logic               valid;
   logic               ready;
   logic               stop_request;
   logic               drives_ok;
   logic               home_a;
   logic               home_b;
   logic signed [31:0] target_a;
   logic signed [31:0] target_b;

   modport source (
      output valid, stop_request, drives_ok, home_a, home_b, target_a, target_b,
      input  ready
   );

   modport sink (
      input  valid, stop_request, drives_ok, home_a, home_b, target_a, target_b,
      output ready
   );
endinterface

// ----- design/ahs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ahs_rsp_if
// Tick result channel: valid/ready handshake plus status and positions.
// ----------------------------------------------------------------------------
interface ahs_rsp_if;
   logic               valid;
   logic               ready;
   logic               power_on;
   logic [3:0]         phase;
   logic               is_running;
   logic               is_fault;
   logic               finished;
   logic signed [31:0] pos_a;
   logic signed [31:0] pos_b;
   logic signed [31:0] steps_a;
   logic signed [31:0] steps_b;

   modport source (
      output valid, power_on, phase, is_running, is_fault, finished,
             pos_a, pos_b, steps_a, steps_b,
      input  ready
   );

   modport sink (
      input  valid, power_on, phase, is_running, is_fault, finished,
             pos_a, pos_b, steps_a, steps_b,
      output ready
   );
endinterface

// ----- design/ahs_tick.sv -----
// ----------------------------------------------------------------------------
// ahs_tick
// Next-state logic for one control tick: phase sequencing, homing moves,
// target clamping and the result fields.
// ----------------------------------------------------------------------------
module ahs_tick #(
   parameter int AXES      = ahs_pkg::AXES_DEFAULT,
   parameter int POS_WIDTH = ahs_pkg::POS_WIDTH_DEFAULT
) (
   input  ahs_pkg::ahs_cfg_type    cfg,
   input  ahs_pkg::ahs_item_type   item,
   input  ahs_pkg::ahs_ctrl_type   ctrl_q,
   input  logic signed [POS_WIDTH-1:0] pos_q [AXES],
   output ahs_pkg::ahs_ctrl_type   ctrl_d,
   output logic signed [POS_WIDTH-1:0] pos_d [AXES],
   output ahs_pkg::ahs_result_type result
);
   import ahs_pkg::*;

   // wide enough for the unwrapped homing sum and for -(max - min)
   localparam int CW = ((POS_WIDTH > FIELD_WIDTH) ? POS_WIDTH : FIELD_WIDTH) + 2;

   ahs_phase_type              ph_eff;
   logic                       seek;
   logic                       tick_finished;
   logic                       any_moved;
   logic                       bad_hit;
   logic [AXES-1:0]            handled;
   logic [AXES-1:0]            moves;
   logic [AXES-1:0]            bad;
   logic signed [CW-1:0]       np [AXES];
   logic signed [FIELD_WIDTH-1:0] clamped [AXES];

   // stop request first, then the drive alarm
   always_comb begin : eff_phase
      ph_eff = ctrl_q.phase;
      if ((ctrl_q.phase inside {[PH_OFF:PH_RUN]}) && item.stop_request) begin
         ph_eff = PH_STOP;
      end
      if ((ph_eff inside {[PH_HOMING:PH_RUN]}) && !item.drives_ok) begin
         ph_eff = PH_ERROR;
      end
   end

   assign seek = (ph_eff == PH_SEEK);

   for (genvar g = 0; g < AXES; g++) begin : g_axis
      logic signed [FIELD_WIDTH-1:0] mx;
      logic signed [FIELD_WIDTH-1:0] mn;
      logic signed [FIELD_WIDTH-1:0] tgt;
      logic signed [CW-1:0]          hs;
      logic signed [CW-1:0]          v;
      logic signed [CW-1:0]          pos_ext;
      logic signed [CW-1:0]          seek_lim;

      assign mx  = $signed(cfg.max_pos[g]);
      assign mn  = $signed(cfg.min_pos[g]);
      assign tgt = $signed(item.target[g]);

      // max is tested first
      assign clamped[g] = (tgt > mx) ? mx : ((tgt < mn) ? mn : tgt);

      assign hs       = $signed(CW'(cfg.home_step[g]));
      assign v        = (seek != item.home[g]) ? hs : '0;
      assign pos_ext  = CW'(pos_q[g]);
      assign np[g]    = seek ? (pos_ext - v) : (pos_ext + v);
      assign seek_lim = CW'(mn) - CW'(mx);
      assign bad[g]   = seek ? (np[g] < seek_lim) : (np[g] > CW'(mx));
      assign moves[g] = (v != '0);
   end

   // an axis that fails ends the pass; later axes stay where they are
   always_comb begin : homing_chain
      logic blocked;
      blocked   = 1'b0;
      any_moved = 1'b0;
      bad_hit   = 1'b0;
      for (int i = 0; i < AXES; i++) begin
         handled[i] = !blocked;
         if (!blocked) begin
            any_moved = any_moved | moves[i];
            if (bad[i]) begin
               bad_hit = 1'b1;
               blocked = 1'b1;
            end
         end
      end
   end

   always_comb begin : next_state
      ctrl_d        = ctrl_q;
      ctrl_d.phase  = ph_eff;
      tick_finished = 1'b0;
      case (ph_eff)
         PH_OFF: begin
            ctrl_d.phase = PH_START;
         end
         PH_START: begin
            ctrl_d.power_on   = 1'b1;
            ctrl_d.wait_count = cfg.power_timeout;
            ctrl_d.phase      = PH_WAIT;
         end
         PH_WAIT: begin
            if (item.drives_ok) begin
               ctrl_d.motion_enable = 1'b1;
               ctrl_d.phase         = PH_HOMING;
            end else if (ctrl_q.wait_count == '0) begin
               ctrl_d.phase = PH_ERROR;
            end else begin
               ctrl_d.wait_count = ctrl_q.wait_count - 1'b1;
            end
         end
         PH_HOMING: begin
            ctrl_d.phase = cfg.skip_homing ? PH_HOMED : PH_SEEK;
         end
         PH_SEEK: begin
            // no motion wins over a failing axis
            if (!any_moved) begin
               ctrl_d.phase = PH_BACK;
            end else if (bad_hit) begin
               ctrl_d.phase = PH_ERROR;
            end
         end
         PH_BACK: begin
            if (!any_moved) begin
               ctrl_d.phase = PH_HOMED;
            end else if (bad_hit) begin
               ctrl_d.phase = PH_ERROR;
            end
         end
         PH_HOMED: begin
            ctrl_d.phase = PH_RUN;
         end
         PH_RUN: begin
         end
         PH_STOP: begin
            ctrl_d.motion_enable = 1'b0;
            ctrl_d.power_on      = 1'b0;
            ctrl_d.phase         = PH_DONE;
         end
         PH_DONE: begin
            tick_finished = 1'b1;
         end
         PH_ERROR: begin
            ctrl_d.motion_enable = 1'b0;
            if (item.stop_request) begin
               ctrl_d.power_on = 1'b0;
               tick_finished   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin : next_pos
      for (int i = 0; i < AXES; i++) begin
         pos_d[i] = pos_q[i];
         case (ph_eff)
            PH_SEEK, PH_BACK: begin
               if (handled[i] && ctrl_q.motion_enable) begin
                  pos_d[i] = POS_WIDTH'(np[i]);
               end
            end
            PH_HOMED: begin
               pos_d[i] = '0;
            end
            PH_RUN: begin
               if (ctrl_q.motion_enable) begin
                  pos_d[i] = POS_WIDTH'(clamped[i]);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin : outputs
      logic signed [FIELD_WIDTH-1:0] old32;
      logic signed [FIELD_WIDTH-1:0] new32;
      result            = '0;
      result.power_on   = ctrl_d.power_on;
      result.phase      = ctrl_d.phase;
      result.is_running = (ctrl_d.phase == PH_RUN);
      result.is_fault   = (ctrl_d.phase == PH_ERROR);
      result.finished   = tick_finished;
      for (int i = 0; i < AXES; i++) begin
         // homing zeroes the reference the step count is taken from
         old32 = (ph_eff == PH_HOMED) ? '0 : FIELD_WIDTH'(pos_q[i]);
         new32 = FIELD_WIDTH'(pos_d[i]);
         result.pos[i]   = new32;
         result.steps[i] = new32 - old32;
      end
   end

endmodule

// ----- design/axis_homing_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// axis_homing_sequencer_top
// One control tick per transfer on req_ch, one result per tick on rsp_ch.
// Ticks are taken at one per clock cycle sustained while rsp_ch is not
// stalled. The tick logic between the input register and the result
// register does all the work for a tick in a single pass. A taken tick
// passes the input register, then the result register, before its result
// is valid on rsp_ch. The tick logic also updates phase and positions, so
// each tick sees the state left by the one before it. A result waiting on
// rsp_ch still lets one more tick into the input register; the tick after
// that waits until the result is taken. The user must write limits, timeout,
// homing step and skip flag through csr_* only while no tick is in flight;
// the block does not enforce this. They take effect on the next tick.
// ----------------------------------------------------------------------------
module axis_homing_sequencer_top #(
   parameter int AXES      = ahs_pkg::AXES_DEFAULT,
   parameter int POS_WIDTH = ahs_pkg::POS_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   ahs_req_if.sink                             req_ch,
   ahs_rsp_if.source                           rsp_ch,
   input  logic                                csr_write_enable,
   input  logic [ahs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ahs_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import ahs_pkg::*;

   ahs_cfg_type    cfg_ff, cfg_in;
   ahs_item_type   item_ff, item_in;
   ahs_ctrl_type   ctrl_ff, ctrl_in;
   ahs_result_type result_ff, result_in;
   logic signed [POS_WIDTH-1:0] pos_ff [AXES];
   logic signed [POS_WIDTH-1:0] pos_in [AXES];
   logic           item_valid_ff, item_valid_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_free;
   logic           advance;
   logic           accept;

   // configuration registers
   always_comb begin : csr_write
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SKIP_HOMING:   cfg_in.skip_homing   = csr_data[0];
            CSR_POWER_TIMEOUT: cfg_in.power_timeout = csr_data[TIMEOUT_WIDTH-1:0];
            CSR_MAX_POS_A:     cfg_in.max_pos[0]    = csr_data[FIELD_WIDTH-1:0];
            CSR_MIN_POS_A:     cfg_in.min_pos[0]    = csr_data[FIELD_WIDTH-1:0];
            CSR_MAX_POS_B:     cfg_in.max_pos[1]    = csr_data[FIELD_WIDTH-1:0];
            CSR_MIN_POS_B:     cfg_in.min_pos[1]    = csr_data[FIELD_WIDTH-1:0];
            CSR_HOME_STEP_A:   cfg_in.home_step[0]  = csr_data[HOME_STEP_WIDTH-1:0];
            CSR_HOME_STEP_B:   cfg_in.home_step[1]  = csr_data[HOME_STEP_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{skip_homing: 1'b0, power_timeout: POWER_TIMEOUT_RESET,
                     max_pos: '0, min_pos: '0, home_step: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake: the result register frees when taken, the input register
   // advances whenever the result register can load
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = item_valid_ff && rsp_free;
   assign req_ch.ready = !item_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   assign item_valid_in = accept ? 1'b1 : (advance ? 1'b0 : item_valid_ff);
   assign rsp_valid_in  = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_comb begin : capture
      item_in = item_ff;
      if (accept) begin
         item_in.stop_request = req_ch.stop_request;
         item_in.drives_ok    = req_ch.drives_ok;
         item_in.home[0]      = req_ch.home_a;
         item_in.home[1]      = req_ch.home_b;
         item_in.target[0]    = req_ch.target_a;
         item_in.target[1]    = req_ch.target_b;
      end
   end

   ahs_tick #(
      .AXES      (AXES),
      .POS_WIDTH (POS_WIDTH)
   ) u_tick (
      .cfg    (cfg_ff),
      .item   (item_ff),
      .ctrl_q (ctrl_ff),
      .pos_q  (pos_ff),
      .ctrl_d (ctrl_in),
      .pos_d  (pos_in),
      .result (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         ctrl_ff       <= '{phase: PH_OFF, wait_count: '0, motion_enable: 1'b0,
                            power_on: 1'b0};
         for (int i = 0; i < AXES; i++) begin
            pos_ff[i] <= '0;
         end
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         // commit state only with the tick that produced it
         if (advance) begin
            ctrl_ff <= ctrl_in;
            pos_ff  <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.power_on   = result_ff.power_on;
   assign rsp_ch.phase      = result_ff.phase;
   assign rsp_ch.is_running = result_ff.is_running;
   assign rsp_ch.is_fault   = result_ff.is_fault;
   assign rsp_ch.finished   = result_ff.finished;
   assign rsp_ch.pos_a      = result_ff.pos[0];
   assign rsp_ch.pos_b      = result_ff.pos[1];
   assign rsp_ch.steps_a    = result_ff.steps[0];
   assign rsp_ch.steps_b    = result_ff.steps[1];

endmodule

// ----- design/ahs_checker.sv -----
// ----------------------------------------------------------------------------
// ahs_checker
// Port-level checks on the result channel of the homing sequencer.
// ----------------------------------------------------------------------------
`include "axis_homing_sequencer_top_assert.svh"

module ahs_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_power_on,
   input logic [3:0]         rsp_phase,
   input logic               rsp_is_running,
   input logic               rsp_is_fault,
   input logic               rsp_finished,
   input logic signed [31:0] rsp_pos_a,
   input logic signed [31:0] rsp_steps_a
);
   import ahs_pkg::*;

   // hold a stalled result
   `AHS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_phase) && $stable(rsp_pos_a) && $stable(rsp_steps_a))

   // status flags follow the reported phase
   `AHS_ASSERT_NOW(a_flags_match, clock, reset, rsp_valid, (rsp_is_running == (rsp_phase == PH_RUN)) && (rsp_is_fault == (rsp_phase == PH_ERROR)))

   // finished only once the sequence has ended
   `AHS_ASSERT_NOW(a_finished_end, clock, reset, rsp_valid && rsp_finished, (rsp_phase == PH_DONE) || (rsp_phase == PH_ERROR))

   // a completed stop leaves the drives unpowered
   `AHS_ASSERT_NOW(a_done_power_off, clock, reset, rsp_valid && (rsp_phase == PH_DONE), !rsp_power_on)

endmodule

bind axis_homing_sequencer_top ahs_checker u_ahs_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_power_on   (rsp_ch.power_on),
   .rsp_phase      (rsp_ch.phase),
   .rsp_is_running (rsp_ch.is_running),
   .rsp_is_fault   (rsp_ch.is_fault),
   .rsp_finished   (rsp_ch.finished),
   .rsp_pos_a      (rsp_ch.pos_a),
   .rsp_steps_a    (rsp_ch.steps_a)
);
